// ===== hw/rtl/id_allocator_fifo_recycle_macros.svh =====
// ----------------------------------------------------------------------------
// id_allocator_fifo_recycle_macros
// Assertion macros for the id allocator, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_FIFO_RECYCLE_MACROS_SVH
`define ID_ALLOCATOR_FIFO_RECYCLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/idalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared widths, codes and control types of the id allocator.
// ----------------------------------------------------------------------------
package idalloc_pkg;

  localparam int NUM_IDS_DEF  = 256;
  localparam int HANDLE_W_DEF = 32;

  // fixed widths of the channel fields
  localparam int MODE_W = 2;
  localparam int SID_W  = 8;
  localparam int HND_W  = 32;
  localparam int STAT_W = 3;
  localparam int LIVE_W = 9;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/idalloc_if.sv =====
// ----------------------------------------------------------------------------
// idalloc_if
// Request and response channels of the id allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface idalloc_req_if;
  import idalloc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SID_W-1:0]  slot_id;
  logic [HND_W-1:0]  handle;
  logic              already_assigned;

  modport source (output valid, mode, slot_id, handle, already_assigned, input ready);
  modport sink   (input valid, mode, slot_id, handle, already_assigned, output ready);
endinterface

interface idalloc_rsp_if;
  import idalloc_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SID_W-1:0]  result_id;
  logic [HND_W-1:0]  result_handle;
  logic [LIVE_W-1:0] live_count;

  modport source (output valid, status, result_id, result_handle, live_count, input ready);
  modport sink   (input valid, status, result_id, result_handle, live_count, output ready);
endinterface

// ===== hw/rtl/idalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// idalloc_ctrl
// Sequencer: captures a request, then commits it once the result register
// is free.
// ----------------------------------------------------------------------------
module idalloc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  idalloc_pkg::dp_stat_t  dp_stat,
  output idalloc_pkg::ctrl_cmd_t cmd
);
  import idalloc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the transaction
        if (dp_stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/idalloc_dp.sv =====
// ----------------------------------------------------------------------------
// idalloc_dp
// Datapath: slot valid, handle and free-id memories, counters and the
// result register.
// ----------------------------------------------------------------------------
module idalloc_dp #(
  parameter int NUM_IDS      = idalloc_pkg::NUM_IDS_DEF,
  parameter int HANDLE_WIDTH = idalloc_pkg::HANDLE_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  idalloc_pkg::ctrl_cmd_t         cmd,
  output idalloc_pkg::dp_stat_t          dp_stat,
  input  logic [idalloc_pkg::MODE_W-1:0] in_mode,
  input  logic [idalloc_pkg::SID_W-1:0]  in_slot_id,
  input  logic [idalloc_pkg::HND_W-1:0]  in_handle,
  input  logic                           in_already_assigned,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [idalloc_pkg::STAT_W-1:0] out_status,
  output logic [idalloc_pkg::SID_W-1:0]  out_result_id,
  output logic [idalloc_pkg::HND_W-1:0]  out_result_handle,
  output logic [idalloc_pkg::LIVE_W-1:0] out_live_count
);
  import idalloc_pkg::*;

  localparam int ID_W  = $clog2(NUM_IDS);
  localparam int CNT_W = $clog2(NUM_IDS + 1);

  // memories, none of them reset
  logic                    valid_mem  [NUM_IDS];
  logic [HANDLE_WIDTH-1:0] handle_mem [NUM_IDS];
  logic [ID_W-1:0]         fifo_mem   [NUM_IDS];

  // captured request
  logic [MODE_W-1:0]       req_mode_r;
  logic [SID_W-1:0]        req_sid_r;
  logic [HANDLE_WIDTH-1:0] req_hnd_r;
  logic                    req_dup_r;

  // registered memory reads
  logic                    rd_valid_r;
  logic [HANDLE_WIDTH-1:0] rd_handle_r;
  logic [ID_W-1:0]         rd_fifo_r;

  logic [CNT_W-1:0] hw_r, hw_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SID_W-1:0]  out_id_r;
  logic [HND_W-1:0]  out_hnd_r;
  logic [LIVE_W-1:0] out_live_r;

  logic [STAT_W-1:0] status_c;
  logic [SID_W-1:0]  rid_c;
  logic [HND_W-1:0]  rhnd_c;

  logic              vld_we;
  logic [ID_W-1:0]   vld_waddr;
  logic              vld_wdata;
  logic              hnd_we;
  logic              fifo_we;
  logic [ID_W-1:0]   fifo_wdata;
  logic [ID_W-1:0]   alloc_id;
  logic              got_id;
  logic [31:0]       sid_w;
  logic [31:0]       hw_w;
  logic              sid_in_num;
  logic              slot_live;
  logic [ID_W-1:0]   rd_addr;

  assign rd_addr = ID_W'(in_slot_id);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode_r <= in_mode;
      req_sid_r  <= in_slot_id;
      req_hnd_r  <= HANDLE_WIDTH'(in_handle);
      req_dup_r  <= in_already_assigned;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_valid_r <= valid_mem[rd_addr];
    end
    if (vld_we) begin
      valid_mem[vld_waddr] <= vld_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_handle_r <= handle_mem[rd_addr];
    end
    if (hnd_we) begin
      handle_mem[alloc_id] <= req_hnd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_fifo_r <= fifo_mem[head_r];
    end
    if (fifo_we) begin
      fifo_mem[tail_r] <= fifo_wdata;
    end
  end

  // ids at or above high water were never handed out, so their valid
  // entries are never looked at
  assign sid_w      = 32'(req_sid_r);
  assign hw_w       = 32'(hw_r);
  assign sid_in_num = sid_w < 32'(NUM_IDS);
  assign slot_live  = (sid_w < hw_w) && rd_valid_r;

  always_comb begin
    status_c   = STAT_OK;
    rid_c      = req_sid_r;
    rhnd_c     = '0;
    hw_nxt     = hw_r;
    fill_nxt   = fill_r;
    occ_nxt    = occ_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    vld_we     = 1'b0;
    vld_waddr  = ID_W'(req_sid_r);
    vld_wdata  = 1'b0;
    hnd_we     = 1'b0;
    fifo_we    = 1'b0;
    fifo_wdata = ID_W'(req_sid_r);
    alloc_id   = '0;
    got_id     = 1'b0;
    case (req_mode_r)
      MODE_ALLOC: begin
        rid_c = '0;
        if (req_dup_r) begin
          status_c = STAT_DUPLICATE;
        end else if (fill_r != '0) begin
          // oldest released id first
          alloc_id = rd_fifo_r;
          head_nxt = (head_r == ID_W'(NUM_IDS - 1)) ? '0 : ID_W'(head_r + 1'b1);
          fill_nxt = CNT_W'(fill_r - 1'b1);
          got_id   = 1'b1;
        end else if (hw_w < 32'(NUM_IDS)) begin
          alloc_id = ID_W'(hw_r);
          hw_nxt   = CNT_W'(hw_r + 1'b1);
          got_id   = 1'b1;
        end else begin
          status_c = STAT_EXHAUSTED;
        end
        if (got_id) begin
          vld_we    = 1'b1;
          vld_waddr = alloc_id;
          vld_wdata = 1'b1;
          hnd_we    = 1'b1;
          occ_nxt   = CNT_W'(occ_r + 1'b1);
          rid_c     = SID_W'(alloc_id);
        end
      end
      MODE_RELEASE: begin
        if (sid_w > hw_w || !sid_in_num) begin
          status_c = STAT_RANGE;
        end else if (!slot_live) begin
          status_c = STAT_EMPTY;
        end else begin
          vld_we = 1'b1;
          if (occ_r != '0) begin
            occ_nxt = CNT_W'(occ_r - 1'b1);
          end
          if (32'(fill_r) < 32'(NUM_IDS)) begin
            fifo_we  = 1'b1;
            tail_nxt = (tail_r == ID_W'(NUM_IDS - 1)) ? '0 : ID_W'(tail_r + 1'b1);
            fill_nxt = CNT_W'(fill_r + 1'b1);
          end
        end
      end
      MODE_LOOKUP: begin
        if (!sid_in_num) begin
          status_c = STAT_RANGE;
        end else if (!slot_live) begin
          status_c = STAT_EMPTY;
        end else begin
          rhnd_c = HND_W'(rd_handle_r);
        end
      end
      default: begin
        status_c = STAT_RANGE;
      end
    endcase
    // memory writes only on the commit cycle
    if (!cmd.commit) begin
      vld_we  = 1'b0;
      hnd_we  = 1'b0;
      fifo_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= '0;
      fill_r <= '0;
      occ_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else if (cmd.commit) begin
      hw_r   <= hw_nxt;
      fill_r <= fill_nxt;
      occ_r  <= occ_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status_c;
      out_id_r     <= rid_c;
      out_hnd_r    <= rhnd_c;
      out_live_r   <= LIVE_W'(occ_nxt);
    end
  end

  assign dp_stat.out_free  = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_handle = out_hnd_r;
  assign out_live_count    = out_live_r;

endmodule

// ===== hw/rtl/id_allocator_fifo_recycle.sv =====
// ----------------------------------------------------------------------------
// id_allocator_fifo_recycle
// Slot id allocator: reuses released ids in FIFO order, else hands out fresh
// ids from a high-water counter; also releases and looks up slot handles.
//
//   channel   dir   fields
//   in_req    in    mode, slot_id, handle, already_assigned
//   out_rsp   out   status, result_id, result_handle, live_count
//
// a transaction is captured in the idle state (memory reads registered), then
// executed in the execute state once the result register is free, where the
// memories and counters are written and the result register loads; no new request is taken until it commits.
// reset clears the counters, the sequencer and the result valid flag; the
// memories need no clearing pass since valid bits are consulted only below
// high water.
// a stalled result holds the next request in the execute step.
// ----------------------------------------------------------------------------
`include "id_allocator_fifo_recycle_macros.svh"

module id_allocator_fifo_recycle #(
  parameter int NUM_IDS      = idalloc_pkg::NUM_IDS_DEF,
  parameter int HANDLE_WIDTH = idalloc_pkg::HANDLE_W_DEF
) (
  input logic           clk,
  input logic           rst_n,
  idalloc_req_if.sink   in_req,
  idalloc_rsp_if.source out_rsp
);
  import idalloc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  dp_stat;

  idalloc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  idalloc_dp #(
    .NUM_IDS      (NUM_IDS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .dp_stat             (dp_stat),
    .in_mode             (in_req.mode),
    .in_slot_id          (in_req.slot_id),
    .in_handle           (in_req.handle),
    .in_already_assigned (in_req.already_assigned),
    .out_valid           (out_rsp.valid),
    .out_ready           (out_rsp.ready),
    .out_status          (out_rsp.status),
    .out_result_id       (out_rsp.result_id),
    .out_result_handle   (out_rsp.result_handle),
    .out_live_count      (out_rsp.live_count)
  );

  `IDA_ASSERT_NOW(a_cap_commit_excl, cmd.capture, !cmd.commit, "capture and commit together")
  `IDA_ASSERT_NEXT(a_busy_after_cap, cmd.capture, !in_req.ready, "request taken while busy")
  `IDA_ASSERT_NEXT(a_commit_loads, cmd.commit, out_rsp.valid, "commit without result")
  `IDA_ASSERT_NOW(a_commit_room, cmd.commit, !out_rsp.valid || out_rsp.ready,
    "result overwritten")

endmodule
